@@ hdl/page_event_coalescing_table_macros.svh @@
// assertion macros for the page event coalescing table
`ifndef PAGE_EVENT_COALESCING_TABLE_MACROS_SVH
`define PAGE_EVENT_COALESCING_TABLE_MACROS_SVH
`ifndef SYNTH
`define PECT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PECT_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PECT_ASSERT(label, clk, rst_n, prop, msg)
`define PECT_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

@@ hdl/pect_pkg.sv @@
`default_nettype none
package pect_pkg;
    localparam int DEFAULT_TABLE_DEPTH = 64;
    localparam int MAX_FETCH = 64;

    localparam logic [2:0] MODEL_DIFF   = 3'd0;
    localparam logic [2:0] MODEL_ACCESS = 3'd1;
    localparam logic [2:0] MODEL_INSERT = 3'd2;
    localparam logic [2:0] MODEL_REMOVE = 3'd3;
    localparam logic [2:0] MODEL_UNION  = 3'd4;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_UPDATED   = 3'd1;
    localparam logic [2:0] ST_REMOVED   = 3'd2;
    localparam logic [2:0] ST_UNCHANGED = 3'd3;
    localparam logic [2:0] ST_FILTERED  = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;
    localparam logic [2:0] ST_FETCHED   = 3'd6;
    localparam logic [2:0] ST_EMPTY     = 3'd7;

    localparam logic CMD_EVENT = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    localparam logic REG_MODEL = 1'b0;
    localparam logic REG_FS    = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [2:0] event_code;
        logic [31:0] file_id;
        logic [31:0] page_index;
        logic [15:0] fs_id;
        logic [6:0] fetch_count;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic        item_valid;
        logic [31:0] out_file_id;
        logic [31:0] out_page_index;
        logic [2:0]  out_event;
        logic        last;
    } t_out_word;

    function automatic logic [2:0] mask_for_model(input logic [2:0] m);
        logic [2:0] r;
        case (m)
            MODEL_DIFF:   r = 3'd3;
            MODEL_ACCESS: r = 3'd5;
            MODEL_INSERT: r = 3'd1;
            MODEL_REMOVE: r = 3'd2;
            MODEL_UNION:  r = 3'd3;
            default:      r = 3'd0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

@@ hdl/pect_if.sv @@
`default_nettype none
interface pect_in_if;
    import pect_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pect_out_if;
    import pect_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/page_event_coalescing_table.sv @@
// channel | dir | payload                                   | handshake
// in_w    | in  | cmd, event_code, file_id, page_index,     | valid/ready
//         |     | fs_id, fetch_count                        |
// out_w   | out | status, item_valid, out_file_id,          | valid/ready
//         |     | out_page_index, out_event, last           |
// apb     | in  | model (0x0), fs_of_interest (0x4)         | psel/penable
//
// an event word scans the table once, then applies the result and presents one output word
// a fetch scans the whole table once per returned entry, since the key memory has only
// a single read port
// synchronous active-low reset empties the table at once (valid bits in flops)
// the block takes no word until every result of the previous word is taken;
// a stalled output simply holds the sequencer in its output state
`default_nettype none
`include "page_event_coalescing_table_macros.svh"
module page_event_coalescing_table #(
    parameter int TABLE_DEPTH = pect_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pect_in_if.sink   in_w,
    pect_out_if.source out_w,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import pect_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;  // issue reads, compare returned data
    localparam logic [2:0] S_DRAIN = 3'd2;  // last read data arriving
    localparam logic [2:0] S_APPLY = 3'd3;  // act on scan result
    localparam logic [2:0] S_OUT   = 3'd4;  // present result word

    logic [2:0]  r_state, n_state;
    logic [2:0]  r_model;
    logic [15:0] r_fs;
    logic [TABLE_DEPTH-1:0] r_valid;

    t_in_word  r_in;
    t_out_word r_out;
    logic [6:0] r_left;       // entries still wanted on a fetch
    logic       r_any;        // a fetch returned at least one entry

    // scan bookkeeping
    logic [AW-1:0] r_raddr;   // address being issued
    logic [AW-1:0] r_caddr;   // address whose data is on the read port
    logic          r_cvalid;  // read data is meaningful this cycle
    logic          r_hit, r_free_ok, r_best_ok;
    logic          r_more;    // another valid entry seen besides the best one
    logic [AW-1:0] r_hit_idx, r_free_idx, r_best_idx;
    logic [63:0]   r_best_key;
    logic [2:0]    r_best_ev;

    // memory ports
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [63:0]   key_wdata, key_rdata;
    logic [2:0]    ev_wdata, ev_rdata;

    pect_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_key (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(mem_waddr), .i_wdata(key_wdata),
        .i_raddr(r_raddr), .o_rdata(key_rdata)
    );
    pect_ram #(.WIDTH(3), .DEPTH(TABLE_DEPTH)) u_ev (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(mem_waddr), .i_wdata(ev_wdata),
        .i_raddr(r_raddr), .o_rdata(ev_rdata)
    );

    // configuration port
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_comb begin
        prdata = 32'd0;
        case (paddr[2])
            REG_MODEL: prdata = {29'd0, r_model};
            REG_FS:    prdata = {16'd0, r_fs};
            default:   prdata = 32'd0;
        endcase
    end

    logic [63:0] in_key;
    logic        filtered;
    logic        cur_valid;
    logic [2:0]  merged;
    assign in_key    = {r_in.file_id, r_in.page_index};
    assign filtered  = ((r_fs != 16'd0) && (r_fs != r_in.fs_id)) ||
                       ((mask_for_model(r_model) & r_in.event_code) == 3'd0);
    assign cur_valid = r_valid[r_caddr];
    assign merged    = r_best_ev | r_in.event_code;

    assign in_w.ready  = (r_state == S_IDLE);
    assign out_w.valid = (r_state == S_OUT);
    assign out_w.data  = r_out;

    // write port: insert or event update
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_free_idx;
        key_wdata = in_key;
        ev_wdata  = r_in.event_code;
        if (r_state == S_APPLY && r_in.cmd == CMD_EVENT && !filtered) begin
            if (!r_hit) begin
                mem_we = r_free_ok;
            end else if (r_model == MODEL_ACCESS) begin
                mem_we    = 1'b1;
                mem_waddr = r_hit_idx;
                key_wdata = r_best_key;
            end else if (r_model == MODEL_UNION) begin
                mem_we    = 1'b1;
                mem_waddr = r_hit_idx;
                key_wdata = r_best_key;
                ev_wdata  = merged;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_w.valid) n_state = S_SCAN;
            S_SCAN:  if (r_raddr == LAST_IDX) n_state = S_DRAIN;
            S_DRAIN: n_state = S_APPLY;
            S_APPLY: n_state = S_OUT;
            S_OUT: begin
                if (out_w.ready) begin
                    n_state = r_out.last ? S_IDLE : S_SCAN;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_model  <= MODEL_DIFF;
            r_fs     <= 16'd0;
            r_valid  <= '0;
            r_cvalid <= 1'b0;
            r_raddr  <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                case (paddr[2])
                    REG_MODEL: r_model <= pwdata[2:0];
                    REG_FS:    r_fs <= pwdata[15:0];
                    default:   r_model <= r_model;
                endcase
            end
            r_cvalid <= (r_state == S_SCAN);
            if (r_state == S_SCAN) begin
                r_raddr <= (r_raddr == LAST_IDX) ? '0 : r_raddr + 1'b1;
            end
            if (r_state == S_APPLY) begin
                if (r_in.cmd == CMD_FETCH) begin
                    if (r_best_ok) r_valid[r_best_idx] <= 1'b0;
                end else if (!filtered) begin
                    if (!r_hit) begin
                        if (r_free_ok) r_valid[r_free_idx] <= 1'b1;
                    end else if (r_model == MODEL_DIFF && r_in.event_code != r_best_ev) begin
                        r_valid[r_hit_idx] <= 1'b0;
                    end
                end
            end
        end
    end

    // payload and scan registers
    always_ff @(posedge i_clk) begin
        r_caddr <= r_raddr;
        if (r_state == S_IDLE && in_w.valid) begin
            r_in   <= in_w.data;
            r_any  <= 1'b0;
            if (in_w.data.fetch_count == 7'd0) r_left <= 7'd1;
            else if (in_w.data.fetch_count > 7'(MAX_FETCH)) r_left <= 7'(MAX_FETCH);
            else r_left <= in_w.data.fetch_count;
        end
        if (n_state == S_SCAN && r_state != S_SCAN) begin
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
            r_best_ok <= 1'b0;
            r_more    <= 1'b0;
        end else if (r_cvalid && r_in.cmd == CMD_EVENT) begin
            if (cur_valid) begin
                if (!r_hit && key_rdata == in_key) begin
                    r_hit      <= 1'b1;
                    r_hit_idx  <= r_caddr;
                    r_best_key <= key_rdata;
                    r_best_ev  <= ev_rdata;
                end
            end else if (!r_free_ok && !r_hit) begin
                r_free_ok  <= 1'b1;
                r_free_idx <= r_caddr;
            end
        end else if (r_cvalid && cur_valid) begin
            if (r_best_ok) r_more <= 1'b1;
            if (!r_best_ok || key_rdata < r_best_key) begin
                r_best_ok  <= 1'b1;
                r_best_idx <= r_caddr;
                r_best_key <= key_rdata;
                r_best_ev  <= ev_rdata;
            end
        end
        if (r_state == S_APPLY) begin
            r_out.item_valid     <= 1'b0;
            r_out.out_file_id    <= 32'd0;
            r_out.out_page_index <= 32'd0;
            r_out.out_event      <= 3'd0;
            r_out.last           <= 1'b1;
            if (r_in.cmd == CMD_FETCH) begin
                if (r_best_ok) begin
                    r_out.status         <= ST_FETCHED;
                    r_out.item_valid     <= 1'b1;
                    r_out.out_file_id    <= r_best_key[63:32];
                    r_out.out_page_index <= r_best_key[31:0];
                    r_out.out_event      <= r_best_ev;
                    // last when the count is used up or no other entry remains
                    r_out.last           <= (r_left == 7'd1) || !r_more;
                    r_left               <= r_left - 7'd1;
                    r_any                <= 1'b1;
                end else begin
                    r_out.status <= ST_EMPTY;
                end
            end else if (filtered) begin
                r_out.status <= ST_FILTERED;
            end else if (!r_hit) begin
                r_out.status <= r_free_ok ? ST_INSERTED : ST_FULL;
            end else begin
                r_out.status <= ST_UNCHANGED;
                case (r_model)
                    MODEL_DIFF:
                        if (r_in.event_code != r_best_ev) r_out.status <= ST_REMOVED;
                    MODEL_ACCESS:
                        if (r_in.event_code != r_best_ev) r_out.status <= ST_UPDATED;
                    MODEL_UNION:
                        if (merged != r_best_ev) r_out.status <= ST_UPDATED;
                    default: r_out.status <= ST_UNCHANGED;
                endcase
            end
        end
    end

    `PECT_ASSERT(a_ready_idle, i_clk, i_rst_n, in_w.ready |-> !out_w.valid, "ready while output pending")
    `PECT_ASSERT(a_out_hold, i_clk, i_rst_n, (out_w.valid && !out_w.ready) |=> (out_w.valid && $stable(out_w.data)), "stalled word changed")
    `PECT_ASSERT(a_fetch_item, i_clk, i_rst_n, (out_w.valid && out_w.data.status == ST_FETCHED) |-> out_w.data.item_valid, "fetched word without entry")
    `PECT_ASSERT(a_nofetch_last, i_clk, i_rst_n, (out_w.valid && !out_w.data.item_valid) |-> out_w.data.last, "event result not last")
    `PECT_ASSERT(a_empty_first, i_clk, i_rst_n, (out_w.valid && out_w.data.status == ST_EMPTY) |-> !r_any, "empty after fetched entries")
endmodule
`default_nettype wire

@@ hdl/pect_ram.sv @@
`default_nettype none
module pect_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import pect_pkg::*;

    localparam int DEPTH = 64;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    pect_in_if  in_w ();
    pect_out_if out_w ();

    page_event_coalescing_table #(.TABLE_DEPTH(DEPTH)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_w(in_w), .out_w(out_w),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow table and registers
    logic [63:0] tbl_key [DEPTH];
    logic [2:0]  tbl_ev [DEPTH];
    logic        tbl_used [DEPTH];
    logic [2:0]  cur_model;
    logic [15:0] cur_fs;

    t_out_word pending_words [$];
    int errors = 0;
    int words_seen = 0;

    function automatic logic [2:0] event_mask(input logic [2:0] m);
        case (m)
            MODEL_DIFF, MODEL_UNION: return 3'd3;
            MODEL_ACCESS: return 3'd5;
            MODEL_INSERT: return 3'd1;
            MODEL_REMOVE: return 3'd2;
            default: return 3'd0;
        endcase
    endfunction

    function automatic t_out_word status_word(input logic [2:0] st);
        t_out_word w;
        w = '0;
        w.status = st;
        w.last = 1'b1;
        return w;
    endfunction

    // computes the words an input word should cause and queues them
    task automatic predict_table(input t_in_word w);
        logic [63:0] key;
        int hit, free, best, want, n;
        logic [2:0] st, merged;
        t_out_word o;
        hit = -1; free = -1; n = 0;
        key = {w.file_id, w.page_index};
        if (w.cmd == CMD_EVENT) begin
            if ((cur_fs != 0 && cur_fs != w.fs_id) ||
                (event_mask(cur_model) & w.event_code) == 0) begin
                pending_words.push_back(status_word(ST_FILTERED));
                return;
            end
            for (int i = 0; i < DEPTH; i++) begin
                if (tbl_used[i]) begin
                    if (tbl_key[i] == key) begin
                        hit = i;
                        break;
                    end
                end else if (free < 0) begin
                    free = i;
                end
            end
            if (hit < 0) begin
                if (free < 0) st = ST_FULL;
                else begin
                    tbl_used[free] = 1'b1;
                    tbl_key[free] = key;
                    tbl_ev[free] = w.event_code;
                    st = ST_INSERTED;
                end
            end else begin
                st = ST_UNCHANGED;
                if (cur_model == MODEL_DIFF) begin
                    if (w.event_code != tbl_ev[hit]) begin
                        tbl_used[hit] = 1'b0;
                        st = ST_REMOVED;
                    end
                end else if (cur_model == MODEL_ACCESS) begin
                    if (w.event_code != tbl_ev[hit]) begin
                        tbl_ev[hit] = w.event_code;
                        st = ST_UPDATED;
                    end
                end else if (cur_model == MODEL_UNION) begin
                    merged = tbl_ev[hit] | w.event_code;
                    if (merged != tbl_ev[hit]) begin
                        tbl_ev[hit] = merged;
                        st = ST_UPDATED;
                    end
                end
            end
            pending_words.push_back(status_word(st));
        end else begin
            want = w.fetch_count;
            if (want == 0) want = 1;
            if (want > MAX_FETCH) want = MAX_FETCH;
            while (n < want) begin
                best = -1;
                for (int i = 0; i < DEPTH; i++)
                    if (tbl_used[i] && (best < 0 || tbl_key[i] < tbl_key[best])) best = i;
                if (best < 0) break;
                tbl_used[best] = 1'b0;
                o = '0;
                o.status = ST_FETCHED;
                o.item_valid = 1'b1;
                {o.out_file_id, o.out_page_index} = tbl_key[best];
                o.out_event = tbl_ev[best];
                o.last = (n + 1 == want);
                pending_words.push_back(o);
                n++;
            end
            if (n == 0) pending_words.push_back(status_word(ST_EMPTY));
            else pending_words[$].last = 1'b1;
        end
    endtask

    // output side: random stall per word, compare with oldest expectation
    initial begin
        t_out_word exp_w;
        int stall;
        out_w.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                out_w.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_w.ready <= 1'b1;
            @(posedge i_clk iff out_w.valid);
            words_seen++;
            if (pending_words.size() == 0) begin
                $error("unexpected word status=%0d", out_w.data.status);
                errors++;
            end else begin
                exp_w = pending_words.pop_front();
                if (out_w.data.status !== exp_w.status) begin
                    $error("status exp %0d got %0d", exp_w.status, out_w.data.status);
                    errors++;
                end
                if (out_w.data.item_valid !== exp_w.item_valid) begin
                    $error("item_valid exp %0d got %0d", exp_w.item_valid,
                           out_w.data.item_valid);
                    errors++;
                end
                if (out_w.data.out_file_id !== exp_w.out_file_id) begin
                    $error("out_file_id exp %h got %h", exp_w.out_file_id,
                           out_w.data.out_file_id);
                    errors++;
                end
                if (out_w.data.out_page_index !== exp_w.out_page_index) begin
                    $error("out_page_index exp %h got %h", exp_w.out_page_index,
                           out_w.data.out_page_index);
                    errors++;
                end
                if (out_w.data.out_event !== exp_w.out_event) begin
                    $error("out_event exp %0d got %0d", exp_w.out_event,
                           out_w.data.out_event);
                    errors++;
                end
                if (out_w.data.last !== exp_w.last) begin
                    $error("last exp %0d got %0d", exp_w.last, out_w.data.last);
                    errors++;
                end
            end
        end
    end

    // apb write: setup then access
    task automatic reg_write(input logic reg_idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk iff pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (reg_idx == REG_MODEL) cur_model = val[2:0];
        else cur_fs = val[15:0];
    endtask

    // waits for the table to drain before touching registers
    task automatic wait_drained();
        in_w.valid <= 1'b0;
        @(posedge i_clk iff pending_words.size() == 0);
        repeat (4 * DEPTH) @(posedge i_clk);
    endtask

    // valid stays high after the accept until the next word or an idle gap
    task automatic send_word(input t_in_word w);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_w.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_w.valid <= 1'b1;
        in_w.data <= w;
        @(posedge i_clk iff in_w.ready);
        predict_table(w);
    endtask

    function automatic t_in_word ev_word(input logic [2:0] code, input logic [31:0] fid,
                                         input logic [31:0] pg, input logic [15:0] fs);
        t_in_word w;
        w = '0;
        w.cmd = CMD_EVENT; w.event_code = code;
        w.file_id = fid; w.page_index = pg; w.fs_id = fs;
        w.fetch_count = 7'($urandom);
        return w;
    endfunction

    function automatic t_in_word fetch_word(input logic [6:0] cnt);
        t_in_word w;
        w = t_in_word'({$urandom, $urandom, $urandom});
        w.cmd = CMD_FETCH;
        w.fetch_count = cnt;
        return w;
    endfunction

    // random event, mostly drawn from a small key pool so that keys collide
    function automatic t_in_word rand_event();
        logic [2:0] code;
        logic [15:0] fs;
        code = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'(1 << $urandom_range(0, 2));
        fs = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(1, 3));
        if ($urandom_range(0, 3) == 0)
            return ev_word(code, $urandom, $urandom, fs);
        return ev_word(code, $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom_range(0, 3),
                       $urandom_range(0, 7), fs);
    endfunction

    typedef struct {
        t_in_word  w;
        logic      known;
        logic [2:0] st;
    } t_row;

    initial begin
        t_row rows [$];
        t_in_word w;
        logic [2:0] models [7];
        logic [15:0] fss [7];
        for (int i = 0; i < DEPTH; i++) begin
            tbl_used[i] = 1'b0; tbl_key[i] = '0; tbl_ev[i] = '0;
        end
        cur_model = MODEL_DIFF; cur_fs = '0;
        in_w.valid <= 1'b0;
        in_w.data <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, diff model, any filesystem after reset
        rows.push_back('{fetch_word(7'd1), 1'b1, ST_EMPTY});
        rows.push_back('{ev_word(3'd1, 32'h0, 32'h0, 16'd1), 1'b1, ST_INSERTED});
        rows.push_back('{ev_word(3'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF), 1'b1,
                         ST_INSERTED});
        rows.push_back('{ev_word(3'd4, 32'h5, 32'h5, 16'd1), 1'b1, ST_FILTERED});
        rows.push_back('{ev_word(3'd0, 32'h5, 32'h5, 16'd1), 1'b1, ST_FILTERED});
        rows.push_back('{ev_word(3'd1, 32'h0, 32'h0, 16'd1), 1'b1, ST_UNCHANGED});
        rows.push_back('{ev_word(3'd2, 32'h0, 32'h0, 16'd1), 1'b1, ST_REMOVED});
        rows.push_back('{ev_word(3'd7, 32'h1, 32'h2, 16'd9), 1'b0, 3'd0});
        rows.push_back('{fetch_word(7'd0), 1'b0, 3'd0});
        rows.push_back('{fetch_word(7'd127), 1'b0, 3'd0});
        foreach (rows[i]) begin
            send_word(rows[i].w);
            if (rows[i].known && pending_words[$].status !== rows[i].st) begin
                $error("status exp %0d got %0d (directed)", rows[i].st,
                       pending_words[$].status);
                errors++;
            end
        end

        // fill table to full, then drain with a large fetch
        for (int i = 0; i <= DEPTH; i++)
            send_word(ev_word(3'd1, 32'h100 - i, 32'(i), 16'd2));
        send_word(fetch_word(7'd64));
        send_word(fetch_word(7'd3));

        // phases through every model, filter and an unknown model
        models = '{MODEL_ACCESS, MODEL_UNION, MODEL_INSERT, MODEL_REMOVE, 3'd7,
                   MODEL_DIFF, MODEL_UNION};
        fss = '{16'd0, 16'd1, 16'hFFFF, 16'd0, 16'd0, 16'd2, 16'd0};
        for (int p = 0; p < 7; p++) begin
            wait_drained();
            reg_write(REG_MODEL, {29'($urandom), models[p]});
            reg_write(REG_FS, {16'($urandom), fss[p]});
            for (int k = 0; k < 20; k++) begin
                if ($urandom_range(0, 7) == 0) w = fetch_word(7'($urandom_range(0, 127)));
                else w = rand_event();
                send_word(w);
            end
        end
        send_word(fetch_word(7'd64));
        in_w.valid <= 1'b0;

        @(posedge i_clk iff pending_words.size() == 0);
        repeat (8 * DEPTH) @(posedge i_clk);
        if (errors == 0)
            $display("[page_event_coalescing_table] OK");
        else
            $display("[page_event_coalescing_table] ERROR");
        $finish;
    end

    initial begin
        #20ms;
        $display("[page_event_coalescing_table] ERROR");
        $finish;
    end
endmodule
